// ===== hdl/gaps_pkg.sv =====
// shared types, constants and helper functions for the grid path search core
// used by every module of the block except the generic ram
package gaps_pkg;

  localparam int GRID_COLS      = 64;
  localparam int GRID_ROWS      = 64;
  localparam int COST_FRAC_BITS = 8;

  localparam int CELLS  = GRID_COLS * GRID_ROWS;
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int IDX_W  = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int D_W    = 8;       // signed coordinate math, one step beyond the grid
  localparam int FLD_W  = 6;       // coordinate fields on the ports
  localparam int LIM_W  = 7;       // cols_in_use / rows_in_use
  localparam int G_W    = 24;
  localparam int F_W    = G_W + 1;
  localparam int H_W    = 15;      // largest heuristic is about 89.1 * 256
  localparam int EXP_W  = 13;
  localparam int SQ_W   = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [G_W-1:0]  G_MAX         = {G_W{1'b1}};
  localparam logic [EXP_W-1:0] EXP_MAX      = {EXP_W{1'b1}};
  localparam logic [G_W-1:0]  STEP_STRAIGHT = G_W'(1) << COST_FRAC_BITS;
  // round(sqrt(2) * 2^8)
  localparam logic [G_W-1:0]  STEP_DIAG     = G_W'(362);
  // highest even power of two below the largest squared distance after scaling
  localparam logic [SQ_W-1:0] SQ_BIT0       = SQ_W'(1) << 28;

  localparam logic [1:0] FLAG_FREE   = 2'b00;
  localparam logic [1:0] FLAG_OPEN   = 2'b01;
  localparam logic [1:0] FLAG_CLOSED = 2'b10;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PATH  = 2'd1,
    ST_FINISHED = 2'd2,
    ST_LOAD_ACK = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_COL = 3'd0,
    CFG_START_ROW = 3'd1,
    CFG_GOAL_COL  = 3'd2,
    CFG_GOAL_ROW  = 3'd3,
    CFG_COLS      = 3'd4,
    CFG_ROWS      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    status_t          status;
    logic [FLD_W-1:0] path_col;
    logic [FLD_W-1:0] path_row;
    logic [G_W-1:0]   path_cost;
    logic [EXP_W-1:0] expanded_count;
    logic             last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic init_sweep;
    logic clr_sweep;
    logic accept;
    logic seed_rd;
    logic seed_ev;
    logic scan_init;
    logic scan;
    logic expand;
    logic nb_rd;
    logic nb_ev;
    logic nb_next;
    logic append;
    logic walk;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic seed_ok;
    logic scan_done;
    logic scan_empty;
    logic is_goal;
    logic nb_new;
    logic nb_last;
    logic h_done;
    logic walk_active;
    logic room;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] cell_index(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
    return IDX_W'(row) * IDX_W'(GRID_COLS) + IDX_W'(col);
  endfunction

  function automatic logic [COL_W-1:0] col_of(input logic [IDX_W-1:0] idx);
    return COL_W'(idx % GRID_COLS);
  endfunction

  function automatic logic [ROW_W-1:0] row_of(input logic [IDX_W-1:0] idx);
    return ROW_W'(idx / GRID_COLS);
  endfunction

  function automatic logic signed [1:0] step_dc(input logic [2:0] d);
    logic signed [1:0] v;
    unique case (d)
      3'd0, 3'd3, 3'd5: v = -2'sd1;
      3'd1, 3'd6:       v = 2'sd0;
      3'd2, 3'd4, 3'd7: v = 2'sd1;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] step_dr(input logic [2:0] d);
    logic signed [1:0] v;
    unique case (d)
      3'd0, 3'd1, 3'd2: v = -2'sd1;
      3'd3, 3'd4:       v = 2'sd0;
      3'd5, 3'd6, 3'd7: v = 2'sd1;
    endcase
    return v;
  endfunction

  function automatic logic is_diag(input logic [2:0] d);
    return (step_dc(d) != 2'sd0) && (step_dr(d) != 2'sd0);
  endfunction

endpackage

// ===== hdl/gaps_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module gaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/gaps_isqrt.sv =====
// rounded integer square root of the scaled squared distance, two bits per cycle
// depends on gaps_pkg
module gaps_isqrt
  import gaps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [D_W-1:0] dc,
  input  logic signed [D_W-1:0] dr,
  output logic                  done,
  output logic [H_W-1:0]        root
);

  logic signed [2*D_W-1:0] sq_c, sq_r;
  logic [2*D_W:0]          sum;
  logic [SQ_W-1:0]         x, r, bitv, trial;
  logic                    busy;

  assign sq_c  = dc * dc;
  assign sq_r  = dr * dr;
  assign sum   = (2*D_W+1)'($unsigned(sq_c)) + (2*D_W+1)'($unsigned(sq_r));
  assign trial = r + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        x    <= SQ_W'(sum) << (2 * COST_FRAC_BITS);
        r    <= '0;
        bitv <= SQ_BIT0;
      end else if (busy) begin
        if (bitv == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          // x holds the remainder, round to nearest
          root <= (x > r) ? H_W'(r + SQ_W'(1)) : H_W'(r);
        end else begin
          if (x >= trial) begin
            x <= x - trial;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end

endmodule

// ===== hdl/gaps_dp.sv =====
// search datapath: stores, open list scan, neighbor update, path walk, result queue
// depends on gaps_pkg, gaps_ram, gaps_isqrt
module gaps_dp
  import gaps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_data,
  input  cmd_t                 in_cmd,
  input  logic [FLD_W-1:0]     in_col,
  input  logic [FLD_W-1:0]     in_row,
  input  logic                 in_blocked,
  output res_t                 out_res,
  output logic                 out_valid,
  input  logic                 out_ready
);

  // configuration
  logic [FLD_W-1:0] start_col, start_row, goal_col, goal_row;
  logic [LIM_W-1:0] cols_in_use, rows_in_use;

  // sequencing
  logic [IDX_W-1:0] ctr;
  logic [CNT_W-1:0] ocnt, scan_pos;
  logic             p1_v, p2_v, best_v;
  logic [IDX_W-1:0] p1_pos, p2_pos, p2_idx;
  logic [IDX_W-1:0] best_idx, best_pos, last_idx;
  logic [F_W-1:0]   best_f;
  logic [G_W-1:0]   best_g;
  logic [2:0]       dir;
  logic [IDX_W-1:0] nb_idx;
  logic             nb_inb, nb_diag;
  logic [EXP_W-1:0] exp_cnt, exp_inc;
  logic [IDX_W-1:0] walk_cursor, walk_start;
  logic             walk_active;

  // rams
  logic             obs_we, flag_we, g_we, dir_we, h_we, list_we;
  logic [IDX_W-1:0] obs_wa, flag_wa, g_wa, dir_wa, h_wa, list_wa;
  logic [IDX_W-1:0] obs_ra, flag_ra, g_ra, h_ra, list_ra;
  logic [0:0]       obs_wd, obs_rd;
  logic [1:0]       flag_wd, flag_rd;
  logic [G_W-1:0]   g_wd, g_rd;
  logic [2:0]       dir_wd, dir_rd;
  logic [H_W-1:0]   h_rd;
  logic [IDX_W-1:0] list_wd, list_rd;

  // heuristic unit
  logic                  h_start, h_done;
  logic [H_W-1:0]        h_root;
  logic [FLD_W-1:0]      h_col, h_row;
  logic signed [D_W-1:0] h_dc, h_dr;

  // combinational helpers
  logic [IDX_W-1:0]      start_idx, ni;
  logic                  seed_ok, scan_issue, scan_done, better, is_goal;
  logic [F_W-1:0]        f;
  logic signed [D_W-1:0] nc, nr, pc, pr;
  logic                  nb_in;
  logic [G_W:0]          tent_full;
  logic [G_W-1:0]        tent;
  logic                  free, improve, nb_new;
  logic                  walk_stop;

  // result queue
  res_t       q0, q1, res_new;
  logic [1:0] qcnt, qcnt_pop;
  logic       push, pop;

  assign start_idx = cell_index(COL_W'(start_col), ROW_W'(start_row));
  assign seed_ok   = (LIM_W'(start_col) < cols_in_use) && (LIM_W'(start_row) < rows_in_use)
                     && !obs_rd[0];

  // open list scan, three stages: list read, cost read, compare
  assign scan_issue = cmd.scan && (scan_pos < ocnt);
  assign scan_done  = cmd.scan && (scan_pos == ocnt) && !p1_v && !p2_v;
  assign f          = F_W'(g_rd) + F_W'(h_rd);
  assign better     = !best_v || (f < best_f) || ((f == best_f) && (p2_idx < best_idx));
  assign is_goal    = (FLD_W'(col_of(best_idx)) == goal_col)
                      && (FLD_W'(row_of(best_idx)) == goal_row);
  assign exp_inc    = (exp_cnt == EXP_MAX) ? exp_cnt : exp_cnt + EXP_W'(1);

  // neighbor of the expanded cell in direction dir
  assign nc = $signed(D_W'(col_of(best_idx))) + D_W'(step_dc(dir));
  assign nr = $signed(D_W'(row_of(best_idx))) + D_W'(step_dr(dir));
  assign nb_in = !nc[D_W-1] && !nr[D_W-1]
                 && (nc < $signed(D_W'(GRID_COLS))) && (nr < $signed(D_W'(GRID_ROWS)))
                 && (nc < $signed(D_W'(cols_in_use))) && (nr < $signed(D_W'(rows_in_use)));
  assign ni = cell_index(nc[COL_W-1:0], nr[ROW_W-1:0]);

  assign tent_full = {1'b0, best_g} + (G_W+1)'(nb_diag ? STEP_DIAG : STEP_STRAIGHT);
  assign tent      = (tent_full > (G_W+1)'(G_MAX)) ? G_MAX : tent_full[G_W-1:0];
  assign free      = nb_inb && !obs_rd[0];
  assign improve   = free && !flag_rd[1] && ((flag_rd == FLAG_FREE) || (tent < g_rd));
  assign nb_new    = improve && (flag_rd == FLAG_FREE);

  // heuristic for the seed or a newly opened neighbor
  assign h_col   = cmd.seed_ev ? start_col : FLD_W'(col_of(nb_idx));
  assign h_row   = cmd.seed_ev ? start_row : FLD_W'(row_of(nb_idx));
  assign h_dc    = $signed(D_W'(h_col)) - $signed(D_W'(goal_col));
  assign h_dr    = $signed(D_W'(h_row)) - $signed(D_W'(goal_row));
  assign h_start = (cmd.seed_ev && seed_ok) || (cmd.nb_ev && nb_new);

  // path walk, one step back along the stored direction
  assign pc = $signed(D_W'(col_of(walk_cursor))) - D_W'(step_dc(dir_rd));
  assign pr = $signed(D_W'(row_of(walk_cursor))) - D_W'(step_dr(dir_rd));
  assign walk_stop = pc[D_W-1] || pr[D_W-1]
                     || (pc >= $signed(D_W'(GRID_COLS))) || (pr >= $signed(D_W'(GRID_ROWS)));

  gaps_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (h_start),
    .dc    (h_dc),
    .dr    (h_dr),
    .done  (h_done),
    .root  (h_root)
  );

  // ram ports
  always_comb begin
    obs_we  = 1'b0;
    obs_wa  = ctr;
    obs_wd  = 1'b0;
    if (cmd.accept && in_cmd == CMD_LOAD) begin
      obs_we = 1'b1;
      obs_wa = cell_index(COL_W'(in_col), ROW_W'(in_row));
      obs_wd = in_blocked;
    end else if (cmd.init_sweep) begin
      obs_we = 1'b1;
    end
    obs_ra = cmd.seed_rd ? start_idx : ni;

    flag_we = 1'b1;
    flag_wa = ctr;
    flag_wd = FLAG_FREE;
    priority if (cmd.clr_sweep) begin
      flag_wa = ctr;
    end else if (cmd.seed_ev && seed_ok) begin
      flag_wa = start_idx;
      flag_wd = FLAG_OPEN;
    end else if (cmd.expand) begin
      flag_wa = best_idx;
      flag_wd = FLAG_CLOSED;
    end else if (cmd.nb_ev && improve) begin
      flag_wa = nb_idx;
      flag_wd = FLAG_OPEN;
    end else begin
      flag_we = 1'b0;
    end
    flag_ra = ni;

    g_we = (cmd.seed_ev && seed_ok) || (cmd.nb_ev && improve);
    g_wa = cmd.seed_ev ? start_idx : nb_idx;
    g_wd = cmd.seed_ev ? '0 : tent;
    g_ra = p1_v ? list_rd : ni;

    dir_we = cmd.nb_ev && improve;
    dir_wa = nb_idx;
    dir_wd = dir;

    h_we = cmd.append;
    h_wa = nb_idx;
    h_ra = list_rd;

    list_we = cmd.expand || cmd.append;
    list_wa = cmd.expand ? best_pos : IDX_W'(ocnt);
    list_wd = cmd.expand ? last_idx : nb_idx;
    list_ra = IDX_W'(scan_pos);
  end

  gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obs_ram (
    .clk(clk), .we(obs_we), .waddr(obs_wa), .wdata(obs_wd), .raddr(obs_ra), .rdata(obs_rd)
  );
  gaps_ram #(.WIDTH(2), .DEPTH(CELLS)) u_flag_ram (
    .clk(clk), .we(flag_we), .waddr(flag_wa), .wdata(flag_wd), .raddr(flag_ra), .rdata(flag_rd)
  );
  gaps_ram #(.WIDTH(G_W), .DEPTH(CELLS)) u_g_ram (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd)
  );
  gaps_ram #(.WIDTH(3), .DEPTH(CELLS)) u_dir_ram (
    .clk(clk), .we(dir_we), .waddr(dir_wa), .wdata(dir_wd), .raddr(walk_cursor), .rdata(dir_rd)
  );
  gaps_ram #(.WIDTH(H_W), .DEPTH(CELLS)) u_h_ram (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_root), .raddr(h_ra), .rdata(h_rd)
  );
  gaps_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_list_ram (
    .clk(clk), .we(list_we), .waddr(list_wa), .wdata(list_wd), .raddr(list_ra), .rdata(list_rd)
  );

  // result for the current item
  always_comb begin
    push    = 1'b0;
    res_new = '0;
    if (cmd.accept) begin
      unique case (in_cmd)
        CMD_LOAD: begin
          push           = 1'b1;
          res_new.status = ST_LOAD_ACK;
        end
        CMD_READ: begin
          push           = !walk_active;
          res_new.status = ST_FINISHED;
        end
        CMD_SEARCH: push = 1'b0;
        default: begin
          push           = 1'b1;
          res_new.status = ST_FINISHED;
        end
      endcase
    end
    if ((cmd.seed_ev && !seed_ok) || (scan_done && !best_v)) begin
      push                   = 1'b1;
      res_new.status         = ST_NO_PATH;
      res_new.expanded_count = exp_cnt;
    end
    if (cmd.expand && is_goal) begin
      push                   = 1'b1;
      res_new.status         = ST_OK;
      res_new.path_cost      = best_g;
      res_new.expanded_count = exp_inc;
    end
    if (cmd.walk) begin
      push                   = 1'b1;
      res_new.status         = ST_OK;
      res_new.path_col       = FLD_W'(col_of(walk_cursor));
      res_new.path_row       = FLD_W'(row_of(walk_cursor));
      res_new.expanded_count = exp_cnt;
      res_new.last           = (walk_cursor == walk_start);
    end
  end

  // two-entry result queue
  assign out_valid = (qcnt != 2'd0);
  assign out_res   = q0;
  assign pop       = out_valid && out_ready;
  assign qcnt_pop  = pop ? qcnt - 2'd1 : qcnt;

  always_ff @(posedge clk) begin
    if (push && qcnt_pop == 2'd0) begin
      q0 <= res_new;
    end else if (pop) begin
      q0 <= q1;
    end
    if (push && qcnt_pop != 2'd0) begin
      q1 <= res_new;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_col   <= '0;
      start_row   <= '0;
      goal_col    <= '0;
      goal_row    <= '0;
      cols_in_use <= LIM_W'(GRID_COLS);
      rows_in_use <= LIM_W'(GRID_ROWS);
      qcnt        <= '0;
      ctr         <= '0;
      ocnt        <= '0;
      scan_pos    <= '0;
      p1_v        <= 1'b0;
      p2_v        <= 1'b0;
      best_v      <= 1'b0;
      dir         <= '0;
      exp_cnt     <= '0;
      walk_cursor <= '0;
      walk_start  <= '0;
      walk_active <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_START_COL: start_col   <= cfg_data[FLD_W-1:0];
          CFG_START_ROW: start_row   <= cfg_data[FLD_W-1:0];
          CFG_GOAL_COL:  goal_col    <= cfg_data[FLD_W-1:0];
          CFG_GOAL_ROW:  goal_row    <= cfg_data[FLD_W-1:0];
          CFG_COLS:      cols_in_use <= cfg_data;
          CFG_ROWS:      rows_in_use <= cfg_data;
          default: ;
        endcase
      end

      qcnt <= qcnt_pop + 2'(push);

      if (cmd.init_sweep || cmd.clr_sweep) begin
        ctr <= (ctr == IDX_W'(CELLS - 1)) ? '0 : ctr + IDX_W'(1);
      end

      if (cmd.accept && in_cmd == CMD_SEARCH) begin
        ctr         <= '0;
        ocnt        <= '0;
        exp_cnt     <= '0;
        walk_active <= 1'b0;
      end

      if (cmd.seed_ev && seed_ok) begin
        walk_start <= start_idx;
      end

      if (cmd.scan_init) begin
        scan_pos <= '0;
        p1_v     <= 1'b0;
        p2_v     <= 1'b0;
        best_v   <= 1'b0;
      end else if (cmd.scan) begin
        scan_pos <= scan_pos + CNT_W'(scan_issue);
        p1_v     <= scan_issue;
        p2_v     <= p1_v;
        if (p2_v && better) begin
          best_v <= 1'b1;
        end
      end

      if (cmd.expand) begin
        ocnt    <= ocnt - CNT_W'(1);
        exp_cnt <= exp_inc;
        dir     <= '0;
        if (is_goal) begin
          walk_cursor <= best_idx;
          walk_active <= 1'b1;
        end
      end

      if (cmd.append) begin
        ocnt <= ocnt + CNT_W'(1);
      end

      if (cmd.nb_next) begin
        dir <= dir + 3'd1;
      end

      if (cmd.walk) begin
        if (walk_cursor == walk_start || walk_stop) begin
          walk_active <= 1'b0;
        end else begin
          walk_cursor <= cell_index(pc[COL_W-1:0], pr[ROW_W-1:0]);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      p1_pos <= IDX_W'(scan_pos);
      p2_pos <= p1_pos;
      p2_idx <= list_rd;
      if (p1_v && (CNT_W'(p1_pos) == ocnt - CNT_W'(1))) begin
        last_idx <= list_rd;
      end
      if (p2_v && better) begin
        best_idx <= p2_idx;
        best_pos <= p2_pos;
        best_f   <= f;
        best_g   <= g_rd;
      end
    end
    if (cmd.seed_ev) begin
      nb_idx <= start_idx;
    end else if (cmd.nb_rd) begin
      nb_idx  <= ni;
      nb_inb  <= nb_in;
      nb_diag <= is_diag(dir);
    end
  end

  always_comb begin
    stat             = '0;
    stat.sweep_done  = (ctr == IDX_W'(CELLS - 1));
    stat.seed_ok     = seed_ok;
    stat.scan_done   = scan_done;
    stat.scan_empty  = !best_v;
    stat.is_goal     = is_goal;
    stat.nb_new      = nb_new;
    stat.nb_last     = (dir == 3'd7);
    stat.h_done      = h_done;
    stat.walk_active = walk_active;
    stat.room        = (qcnt != 2'd2) || out_ready;
  end

endmodule

// ===== hdl/gaps_ctrl.sv =====
// search sequencer: clearing passes, scan / expand / neighbor loop, path reads
// depends on gaps_pkg
module gaps_ctrl
  import gaps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  cmd_t     in_cmd,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_INIT    = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_CLR     = 12'b0000_0000_0100,
    S_SEED_RD = 12'b0000_0000_1000,
    S_SEED_EV = 12'b0000_0001_0000,
    S_SEED_H  = 12'b0000_0010_0000,
    S_SCAN    = 12'b0000_0100_0000,
    S_EXPAND  = 12'b0000_1000_0000,
    S_NB_RD   = 12'b0001_0000_0000,
    S_NB_EV   = 12'b0010_0000_0000,
    S_NB_H    = 12'b0100_0000_0000,
    S_WALK    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.init_sweep = 1'b1;
        if (stat.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = stat.room;
        if (in_valid && stat.room) begin
          cmd.accept = 1'b1;
          if (in_cmd == CMD_SEARCH) begin
            state_next = S_CLR;
          end else if (in_cmd == CMD_READ && stat.walk_active) begin
            state_next = S_WALK;
          end
        end
      end
      S_CLR: begin
        cmd.clr_sweep = 1'b1;
        if (stat.sweep_done) state_next = S_SEED_RD;
      end
      S_SEED_RD: begin
        cmd.seed_rd = 1'b1;
        state_next  = S_SEED_EV;
      end
      S_SEED_EV: begin
        cmd.seed_ev = 1'b1;
        state_next  = stat.seed_ok ? S_SEED_H : S_IDLE;
      end
      S_SEED_H: begin
        if (stat.h_done) begin
          cmd.append    = 1'b1;
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_next = stat.scan_empty ? S_IDLE : S_EXPAND;
      end
      S_EXPAND: begin
        cmd.expand = 1'b1;
        state_next = stat.is_goal ? S_IDLE : S_NB_RD;
      end
      S_NB_RD: begin
        cmd.nb_rd  = 1'b1;
        state_next = S_NB_EV;
      end
      S_NB_EV: begin
        cmd.nb_ev = 1'b1;
        if (stat.nb_new) begin
          state_next = S_NB_H;
        end else if (stat.nb_last) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          cmd.nb_next = 1'b1;
          state_next  = S_NB_RD;
        end
      end
      S_NB_H: begin
        if (stat.h_done) begin
          cmd.append = 1'b1;
          if (stat.nb_last) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end else begin
            cmd.nb_next = 1'b1;
            state_next  = S_NB_RD;
          end
        end
      end
      S_WALK: begin
        cmd.walk   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/grid_astar_path_search_core.sv =====
// top level of the 8-connected grid A* path search core
// depends on gaps_pkg, gaps_ctrl, gaps_dp
//
// After reset the block clears the obstacle map and takes no item in that time;
// configuration writes are taken at any time. A map load is answered from the idle
// state, and a path read with a path pending goes through the walk state. A search
// first clears the open and closed flags, then per expanded cell scans the open list
// at one entry per cycle, closes the cell in the expand state, reads and evaluates
// each neighbor in turn, and waits on the square-root unit for each newly opened
// cell. The open-list scan and the heuristic root set the search time. Results go
// through a two-entry queue, so a new item is taken while a result waits.
module grid_astar_path_search_core
  import gaps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // cell_col, cell_row, cell_blocked
  input  logic [1:0]           s_axis_tuser,   // cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [55:0]          m_axis_tdata,   // path_col, path_row, path_cost, expanded_count
  output logic [1:0]           m_axis_tuser,   // status
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     res;
  cmd_t     in_cmd;

  assign in_cmd    = cmd_t'(s_axis_tuser);
  assign cfg_ready = 1'b1;

  gaps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (in_cmd),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gaps_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_cmd     (in_cmd),
    .in_col     (s_axis_tdata[5:0]),
    .in_row     (s_axis_tdata[11:6]),
    .in_blocked (s_axis_tdata[12]),
    .out_res    (res),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready)
  );

  assign m_axis_tdata = {7'b0, res.expanded_count, res.path_cost, res.path_row, res.path_col};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

  // a search holds off input right after it is taken
  a_search_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_SEARCH) |=> !s_axis_tready)
    else $error("input taken right after a search beat");

  // a load answers in the next cycle
  a_load_answers: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOAD) |=> m_axis_tvalid)
    else $error("no result after a load beat");

  // a load acknowledge carries nothing else
  a_ack_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_LOAD_ACK) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("load acknowledge with payload");

  // expansions never exceed the cell count
  a_exp_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[48:36] <= EXP_W'(CELLS)))
    else $error("expanded count beyond grid size");

endmodule
